[hw/rtl/point_hash_set_quadratic_probe_core_assert.svh]
// Assertion macros used by the point hash set core.
`ifndef POINT_HASH_SET_QUADRATIC_PROBE_CORE_ASSERT_SVH
`define POINT_HASH_SET_QUADRATIC_PROBE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

[hw/rtl/phs_pkg.sv]
// Types and constants of the point hash set.
package phs_pkg;

    localparam int COUNT_W = 9;

    // Home slot is ((x + HASH_X_OFS) * (y + HASH_Y_OFS) * HASH_MUL + HASH_ADD) mod capacity.
    localparam int HASH_X_OFS = 79;
    localparam int HASH_Y_OFS = 37;
    localparam int HASH_MUL   = 19;
    localparam int HASH_ADD   = 102793;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_FIX,
        ST_LOAD,
        ST_PROBE,
        ST_DONE
    } state_t;

    // Which value the shared modular reduction is working on.
    typedef enum logic [1:0] {
        PASS_X,
        PASS_Y,
        PASS_PROD,
        PASS_SCALE
    } pass_t;

endpackage

[hw/rtl/phs_req_if.sv]
// Request channel: operation and coordinate pair.
interface phs_req_if #(
    parameter int COORD_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;

    modport source (output valid, output op, output x, output y, input ready);
    modport sink   (input valid, input op, input x, input y, output ready);
endinterface

[hw/rtl/phs_rsp_if.sv]
// Response channel: lookup and insert outcome with the stored count.
interface phs_rsp_if import phs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic               inserted;
    logic               full_res;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output found, output inserted, output full_res,
                    output count, input ready);
    modport sink   (input valid, input found, input inserted, input full_res,
                    input count, output ready);
endinterface

[hw/rtl/point_hash_set_quadratic_probe_core.sv]
// Point hash set: open-addressed table of coordinate pairs with quadratic probing.
`include "point_hash_set_quadratic_probe_core_assert.svh"

// The block holds a set of (x, y) pairs in one single-port-read table memory of CAPACITY
// entries, each a used bit and the packed pair. After reset it clears every entry of the
// table and takes no request word until that pass ends. A request is taken one at a
// time: it is accepted, its home slot is formed by four passes through one shared
// reciprocal-multiply reduction (multiply, subtract, fix and load steps each), the table
// is probed at one memory read per cycle for 1 to CAPACITY probes, and the response is
// posted once its register is free. The response sits in its own register, so the next
// request is taken while it waits to be read.
module point_hash_set_quadratic_probe_core import phs_pkg::*; #(
    parameter int CAPACITY   = 503,
    parameter int COORD_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    phs_req_if.sink     req,
    phs_rsp_if.source   rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int KEY_W = 2 * COORD_BITS;
    localparam int ENT_W = KEY_W + 1;
    localparam int RAW_W = ((COORD_BITS > 7) ? COORD_BITS : 7) + 1;
    localparam int HALF  = CAPACITY / 2;
    localparam int CNT_W = $clog2(HALF + 2);
    localparam int EXT_W = CNT_W + COUNT_W;

    localparam logic [31:0]    CAP_W        = 32'(CAPACITY);
    localparam logic [31:0]    RECIP        = 32'((64'd1 << 32) / CAPACITY);
    localparam logic [31:0]    HASH_ADD_MOD = 32'(HASH_ADD % CAPACITY);
    localparam logic [IDX_W:0] CAP_X        = (IDX_W + 1)'(CAPACITY);

    logic [ENT_W-1:0] mem [CAPACITY];

    state_t state_reg, state_next;
    pass_t  pass_reg;

    logic [IDX_W-1:0] clr_idx_reg;
    logic [CNT_W-1:0] count_reg;

    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [31:0]      v_reg;
    logic [63:0]      prod_reg;
    logic [IDX_W-1:0] a_reg;
    logic [RAW_W-1:0] b_raw_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] incr_reg;
    logic [IDX_W-1:0] pcnt_reg;
    logic [ENT_W-1:0] rd_data_reg;

    logic res_found_reg, res_ins_reg, res_full_reg;

    logic               rsp_valid_reg;
    logic               rsp_found_reg, rsp_ins_reg, rsp_full_reg;
    logic [COUNT_W-1:0] rsp_count_reg;

    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             wr_en;
    logic             req_ready;
    logic             probe_end;
    logic             wr_ins;

    logic [IDX_W:0]   pos_sum, incr_sum;
    logic [IDX_W-1:0] adv_pos, adv_incr;
    logic             hit_empty, hit_match, probe_last;
    logic             full_hit, ins_ok;
    logic             out_free;
    logic [EXT_W-1:0] cnt_ext;

    // Next probe position moves forward by the running odd increment.
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, incr_reg};
    assign adv_pos  = (pos_sum >= CAP_X) ? IDX_W'(pos_sum - CAP_X) : pos_sum[IDX_W-1:0];
    assign incr_sum = {1'b0, incr_reg} + (IDX_W + 1)'(2);
    assign adv_incr = (incr_sum >= CAP_X) ? IDX_W'(incr_sum - CAP_X) : incr_sum[IDX_W-1:0];

    assign hit_empty  = !rd_data_reg[KEY_W];
    assign hit_match  = rd_data_reg[KEY_W] && (rd_data_reg[KEY_W-1:0] == key_reg);
    assign probe_last = (pcnt_reg == IDX_W'(CAPACITY - 1));
    assign full_hit   = op_reg && !hit_match && ((count_reg > CNT_W'(HALF)) || !hit_empty);
    assign ins_ok     = op_reg && !hit_match && !full_hit;

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign cnt_ext  = EXT_W'(count_reg);

    assign req.ready    = req_ready;
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.found    = rsp_found_reg;
    assign rsp.inserted = rsp_ins_reg;
    assign rsp.full_res = rsp_full_reg;
    assign rsp.count    = rsp_count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_SUB;
            ST_SUB:   state_next = ST_FIX;
            ST_FIX:   state_next = ST_LOAD;
            ST_LOAD:
            begin
                state_next = (pass_reg == PASS_SCALE) ? ST_PROBE : ST_MUL;
            end
            ST_PROBE:
            begin
                if (probe_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rd_addr   = pos_reg;
        wr_en     = 1'b0;
        wr_addr   = pos_reg;
        wr_data   = {1'b1, key_reg};
        req_ready = 1'b0;
        probe_end = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = '0;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_LOAD:
            begin
                // Issue the read of the home slot as the hash completes.
                if (pass_reg == PASS_SCALE)
                begin
                    rd_addr = v_reg[IDX_W-1:0];
                end
            end
            ST_PROBE:
            begin
                // The next slot is read speculatively while this one is examined.
                rd_addr   = adv_pos;
                probe_end = hit_empty || hit_match || probe_last;
                wr_en     = probe_end && ins_ok;
            end
            default:
            begin
            end
        endcase
    end

    assign wr_ins = wr_en && (state_reg == ST_PROBE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pass_reg      <= PASS_X;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (state_reg == ST_IDLE && req.valid)
            begin
                pass_reg <= PASS_X;
            end
            else if (state_reg == ST_LOAD)
            begin
                unique case (pass_reg)
                    PASS_X:    pass_reg <= PASS_Y;
                    PASS_Y:    pass_reg <= PASS_PROD;
                    PASS_PROD: pass_reg <= PASS_SCALE;
                    default:   pass_reg <= PASS_X;
                endcase
            end
            if (wr_ins)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (state_reg == ST_DONE && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_reg    <= req.op;
                    key_reg   <= {req.y, req.x};
                    v_reg     <= 32'(RAW_W'(req.x) + RAW_W'(HASH_X_OFS));
                    b_raw_reg <= RAW_W'(req.y) + RAW_W'(HASH_Y_OFS);
                end
            end
            ST_MUL:
            begin
                // Quotient estimate from the reciprocal; low by at most one.
                prod_reg <= 64'(v_reg) * 64'(RECIP);
            end
            ST_SUB:
            begin
                v_reg <= v_reg - (prod_reg[63:32] * CAP_W);
            end
            ST_FIX:
            begin
                v_reg <= (v_reg >= CAP_W) ? (v_reg - CAP_W) : v_reg;
            end
            ST_LOAD:
            begin
                unique case (pass_reg)
                    PASS_X:
                    begin
                        a_reg <= v_reg[IDX_W-1:0];
                        v_reg <= 32'(b_raw_reg);
                    end
                    PASS_Y:
                    begin
                        v_reg <= 32'(a_reg) * 32'(v_reg[IDX_W-1:0]);
                    end
                    PASS_PROD:
                    begin
                        v_reg <= v_reg * 32'(HASH_MUL) + HASH_ADD_MOD;
                    end
                    default:
                    begin
                        pos_reg  <= v_reg[IDX_W-1:0];
                        incr_reg <= IDX_W'(1);
                        pcnt_reg <= '0;
                    end
                endcase
            end
            ST_PROBE:
            begin
                if (probe_end)
                begin
                    res_found_reg <= hit_match;
                    res_ins_reg   <= ins_ok;
                    res_full_reg  <= full_hit;
                end
                else
                begin
                    pos_reg  <= adv_pos;
                    incr_reg <= adv_incr;
                    pcnt_reg <= pcnt_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_found_reg <= res_found_reg;
                    rsp_ins_reg   <= res_ins_reg;
                    rsp_full_reg  <= res_full_reg;
                    rsp_count_reg <= cnt_ext[COUNT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_NEXT(a_count_step, clk, rst_n, wr_ins, count_reg == $past(count_reg) + CNT_W'(1), "stored count did not advance on insert")
    `ASSERT_IMPLIES(a_rsp_excl, clk, rst_n, rsp_valid_reg, !(rsp_ins_reg && (rsp_found_reg || rsp_full_reg)), "insert reported together with found or full")
    `ASSERT_IMPLIES(a_probe_range, clk, rst_n, state_reg == ST_PROBE, (32'(pos_reg) < CAP_W) && (32'(incr_reg) < CAP_W), "probe position out of table range")

endmodule

[dv/point_hash_set_quadratic_probe_core_test.sv]
// Self-checking testbench for the point hash set core with quadratic probing.
module point_hash_set_quadratic_probe_core_test import phs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 503;
    localparam int COORD_BITS = 12;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int KEY_W      = 2 * COORD_BITS;
    localparam int SEG_WORDS  = 210;
    // The slowest correct item walks every slot and waits out long gaps and stalls.
    localparam int CYCLE_LIMIT = 4_000_000;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } request_t;

    typedef struct packed {
        logic               found;
        logic               inserted;
        logic               full_res;
        logic [COUNT_W-1:0] count;
    } outcome_t;

    logic clk;
    logic rst_n;

    phs_req_if #(.COORD_BITS(COORD_BITS)) req ();
    phs_rsp_if rsp ();

    point_hash_set_quadratic_probe_core #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow of the pair set.
    bit                slot_full [CAPACITY];
    logic [KEY_W-1:0]  slot_key  [CAPACITY];
    int unsigned       pairs_held;

    // Slots reached from one chosen home; filling all of them exhausts that chain.
    bit                on_chain [CAPACITY];
    int unsigned       chain_home;
    request_t          fill_plan [$];

    request_t          pending_words [$];
    outcome_t          outcomes_due [$];
    request_t          head;
    outcome_t          want;
    int                send_idle;
    int                recv_stall;
    int                mismatches;
    int                cycles;

    function automatic int unsigned home_of(input logic [COORD_BITS-1:0] px,
                                            input logic [COORD_BITS-1:0] py);
        longint unsigned hx;
        longint unsigned hy;
        hx = 64'(px);
        hy = 64'(py);
        hx = hx + HASH_X_OFS;
        hy = hy + HASH_Y_OFS;
        return int'((hx * hy * HASH_MUL + HASH_ADD) % CAPACITY);
    endfunction

    // Walks the probe sequence until a match, an empty slot, or CAPACITY probes.
    function automatic void walk_chain(input logic [KEY_W-1:0] key, input int unsigned start,
                                       output bit hit, output bit has_gap,
                                       output int unsigned gap);
        int unsigned pos;
        int unsigned step;
        pos     = start;
        step    = 0;
        hit     = 1'b0;
        has_gap = 1'b0;
        gap     = 0;
        while (!hit && !has_gap && step < CAPACITY)
        begin
            if (!slot_full[pos])
            begin
                has_gap = 1'b1;
                gap     = pos;
            end
            else if (slot_key[pos] == key)
                hit = 1'b1;
            else
            begin
                pos  = (pos + 2 * step + 1) % CAPACITY;
                step = step + 1;
            end
        end
    endfunction

    function automatic outcome_t set_outcome(input request_t rq);
        outcome_t         o;
        bit               hit;
        bit               has_gap;
        int unsigned      gap;
        logic [KEY_W-1:0] key;
        key = {rq.y, rq.x};
        walk_chain(key, home_of(rq.x, rq.y), hit, has_gap, gap);
        o.found    = hit;
        o.inserted = 1'b0;
        o.full_res = 1'b0;
        if (rq.op == OP_INSERT && !hit)
        begin
            if (pairs_held > CAPACITY / 2 || !has_gap)
                o.full_res = 1'b1;
            else
            begin
                slot_full[gap] = 1'b1;
                slot_key[gap]  = key;
                pairs_held     = pairs_held + 1;
                o.inserted     = 1'b1;
            end
        end
        o.count = pairs_held[COUNT_W-1:0];
        return o;
    endfunction

    function automatic void clear_set();
        int unsigned i;
        for (i = 0; i < CAPACITY; i++)
        begin
            slot_full[i] = 1'b0;
            slot_key[i]  = '0;
        end
        pairs_held = 0;
    endfunction

    function automatic void mark_chain(input int unsigned from);
        int unsigned i;
        for (i = 0; i < CAPACITY; i++)
            on_chain[i] = 1'b0;
        for (i = 0; i < CAPACITY; i++)
            on_chain[(from + i * i) % CAPACITY] = 1'b1;
    endfunction

    function automatic request_t any_pair(input logic op);
        request_t rq;
        rq.op = op;
        rq.x  = COORD_BITS'($urandom_range(COORD_MAX));
        rq.y  = COORD_BITS'($urandom_range(COORD_MAX));
        return rq;
    endfunction

    function automatic request_t pair_at_home(input int unsigned target, input logic op);
        request_t rq;
        rq = any_pair(op);
        while (home_of(rq.x, rq.y) != target)
            rq = any_pair(op);
        return rq;
    endfunction

    task automatic drain_all();
        while (pending_words.size() != 0 || req.valid || outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Request driver: the expected outcome is formed when a word is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.op    <= OP_LOOKUP;
            req.x     <= '0;
            req.y     <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                outcomes_due.push_back(set_outcome(request_t'({req.op, req.x, req.y})));
            if (!req.valid || req.ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    head = pending_words.pop_front();
                    req.valid <= 1'b1;
                    req.op    <= head.op;
                    req.x     <= head.x;
                    req.y     <= head.y;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Response monitor.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $error("response word with no request outstanding");
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp.found);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.inserted !== want.inserted)
                    begin
                        $error("inserted: expected %0d, got %0d", want.inserted, rsp.inserted);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.full_res !== want.full_res)
                    begin
                        $error("full_res: expected %0d, got %0d", want.full_res, rsp.full_res);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, rsp.count);
                        mismatches = mismatches + 1;
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin
        request_t    corner [4];
        request_t    rq;
        bit          hit;
        bit          has_gap;
        bit          ok;
        bit          found_head;
        bit          placed;
        bit          stuck;
        int unsigned gap;
        int unsigned cand;
        int unsigned offset;
        int unsigned filled;
        int unsigned pick;
        int unsigned s;
        int          k;
        int          j;
        int          t;
        int          seg;
        int          n;

        rst_n      = 1'b0;
        req.valid  = 1'b0;
        req.op     = OP_LOOKUP;
        req.x      = '0;
        req.y      = '0;
        rsp.ready  = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        mismatches = 0;
        cycles     = 0;

        corner[0] = '{op: OP_INSERT, x: '0, y: '0};
        corner[1] = '{op: OP_INSERT, x: '1, y: '1};
        corner[2] = '{op: OP_INSERT, x: '0, y: '1};
        corner[3] = '{op: OP_INSERT, x: '1, y: '0};

        // Pick a home whose chain takes the corner pairs, then plan a fill of exactly
        // that chain so a later lookup there walks every probe without an empty slot.
        chain_home = home_of('0, '0);
        found_head = 1'b0;
        offset     = $urandom_range(CAPACITY - 1);
        for (k = 0; k < CAPACITY && !found_head; k++)
        begin
            cand = (offset + k) % CAPACITY;
            mark_chain(cand);
            clear_set();
            ok = 1'b1;
            for (j = 0; j < 4; j++)
            begin
                walk_chain({corner[j].y, corner[j].x}, home_of(corner[j].x, corner[j].y),
                           hit, has_gap, gap);
                if (hit || !has_gap || !on_chain[gap])
                    ok = 1'b0;
                else
                    void'(set_outcome(corner[j]));
            end
            if (ok)
            begin
                found_head = 1'b1;
                chain_home = cand;
            end
        end
        mark_chain(chain_home);
        clear_set();
        for (j = 0; j < 4; j++)
        begin
            void'(set_outcome(corner[j]));
            fill_plan.push_back(corner[j]);
        end

        stuck = 1'b0;
        while (fill_plan.size() <= CAPACITY / 2 && !stuck)
        begin
            placed = 1'b0;
            for (t = 0; t < 64 && !placed; t++)
            begin
                rq = any_pair(OP_INSERT);
                walk_chain({rq.y, rq.x}, home_of(rq.x, rq.y), hit, has_gap, gap);
                if (!hit && has_gap && on_chain[gap])
                    placed = 1'b1;
            end
            if (!placed)
            begin
                // Aim straight at an empty chain slot.
                stuck = 1'b1;
                for (s = 0; s < CAPACITY && stuck; s++)
                    if (on_chain[s] && !slot_full[s])
                    begin
                        rq     = pair_at_home(s, OP_INSERT);
                        stuck  = 1'b0;
                        placed = 1'b1;
                    end
            end
            if (placed)
            begin
                void'(set_outcome(rq));
                fill_plan.push_back(rq);
            end
        end
        clear_set();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Opening words: misses on the empty set, corner inserts, a duplicate,
        // hits, and a miss that collides with a stored pair.
        rq = corner[0];
        rq.op = OP_LOOKUP;
        pending_words.push_back(rq);
        rq = corner[1];
        rq.op = OP_LOOKUP;
        pending_words.push_back(rq);
        for (j = 0; j < 4; j++)
            pending_words.push_back(corner[j]);
        pending_words.push_back(corner[0]);
        for (j = 3; j >= 0; j--)
        begin
            rq = corner[j];
            rq.op = OP_LOOKUP;
            pending_words.push_back(rq);
        end
        pending_words.push_back(pair_at_home(home_of('0, '0), OP_LOOKUP));
        pending_words.push_back(pair_at_home(home_of('1, '1), OP_LOOKUP));
        filled = 4;
        drain_all();

        for (seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 82;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 82;
                end
                default:
                begin
                    send_idle  = 8;
                    recv_stall = 8;
                end
            endcase
            if (seg == 4)
            begin
                while (filled < fill_plan.size())
                begin
                    pending_words.push_back(fill_plan[filled]);
                    filled = filled + 1;
                end
                // At the load limit: a refused new pair, a duplicate that is still
                // found, and searches that exhaust the filled chain.
                pending_words.push_back(any_pair(OP_INSERT));
                pending_words.push_back(corner[1]);
                pending_words.push_back(pair_at_home(chain_home, OP_LOOKUP));
                pending_words.push_back(pair_at_home(chain_home, OP_INSERT));
                pending_words.push_back(pair_at_home(chain_home, OP_LOOKUP));
            end
            for (n = 0; n < SEG_WORDS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                begin
                    if (seg < 4 && filled < fill_plan.size())
                    begin
                        rq = fill_plan[filled];
                        filled = filled + 1;
                    end
                    else
                        rq = any_pair(OP_INSERT);
                end
                else if (pick < 45)
                begin
                    rq = fill_plan[$urandom_range(filled - 1)];
                    rq.op = OP_INSERT;
                end
                else if (pick < 80)
                begin
                    rq = fill_plan[$urandom_range(filled - 1)];
                    rq.op = OP_LOOKUP;
                end
                else if (pick < 95 || seg < 4)
                    rq = any_pair(OP_LOOKUP);
                else
                    rq = pair_at_home(chain_home, OP_LOOKUP);
                pending_words.push_back(rq);
            end
            while (pending_words.size() != 0)
                @(posedge clk);
        end

        drain_all();
        repeat (CAPACITY + 32) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
